// ----- rtl/lgge_pkg.sv -----
// lgge_pkg: shared constants, codes and types of the life grid generation engine
// no dependencies; compiled first

package lgge_pkg;

	localparam int LGGE_GRID_ROWS_DEF = 128;
	localparam int LGGE_GRID_COLS_DEF = 128;

	localparam int ACTION_W = 3;
	localparam int ROW_W    = 7;
	localparam int COL_W    = 7;
	localparam int GEN_W    = 32;
	localparam int CFG_W    = 8;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [CFG_W-1:0] ROWS_USED_RST = CFG_W'(100);
	localparam logic [CFG_W-1:0] COLS_USED_RST = CFG_W'(100);

	typedef enum logic [0:0] {
		REG_ROWS_USED = 1'b0,
		REG_COLS_USED = 1'b1
	} reg_idx_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_STEP  = 3'd0,
		ACT_FLIP  = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_CLEAR = 3'd3,
		ACT_READ  = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CELL,
		S_CLR,
		S_CLR_TAIL,
		S_STEP,
		S_STEP_DRAIN,
		S_STEP_LAST,
		S_DONE
	} state_t;

endpackage

// ----- rtl/lgge_if.sv -----
// lgge_in_if / lgge_out_if: valid-ready channels for commands and results
// depends on lgge_pkg for field widths

interface lgge_in_if;
	import lgge_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ROW_W-1:0]    row;
	logic [COL_W-1:0]    col;
	logic                value;

	modport source (output valid, action, row, col, value, input ready);
	modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface lgge_out_if;
	import lgge_pkg::*;
	logic             valid;
	logic             ready;
	logic             cell_state;
	logic [GEN_W-1:0] generation;
	logic             changed;
	logic             out_of_range;

	modport source (output valid, cell_state, generation, changed, out_of_range, input ready);
	modport sink   (input valid, cell_state, generation, changed, out_of_range, output ready);
endinterface

// ----- rtl/lgge_ram.sv -----
// lgge_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; read returns the old word on a same-address write

module lgge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/lgge_row_rule.sv -----
// lgge_row_rule: b3/s23 update of one grid row from the old rows above and below
// no package use; columns outside the mask read as dead and keep their stored bits

module lgge_row_rule #(
	parameter int COLS = 128
) (
	input  logic [COLS-1:0] above,
	input  logic [COLS-1:0] here,
	input  logic [COLS-1:0] below,
	input  logic [COLS-1:0] mask,
	output logic [COLS-1:0] nxt,
	output logic            chg
);

	logic [COLS+1:0] ap, hp, bp;
	logic [COLS-1:0] born;

	assign ap = {1'b0, above & mask, 1'b0};
	assign hp = {1'b0, here & mask, 1'b0};
	assign bp = {1'b0, below & mask, 1'b0};

	always_comb begin
		logic [3:0] n;
		born = '0;
		for (int c = 0; c < COLS; c++) begin
			n = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2]) + 4'(hp[c]) + 4'(hp[c+2])
				+ 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
			born[c] = (n == 4'd3) || (hp[c+1] && (n == 4'd2));
		end
	end

	assign nxt = (born & mask) | (here & ~mask);
	assign chg = |((born ^ here) & mask);

endmodule

// ----- rtl/life_grid_generation_engine.sv -----
// life_grid_generation_engine: conway b3/s23 grid held in one row-wide ram
// depends on lgge_pkg, lgge_if, lgge_ram and lgge_row_rule
//
// The grid lives in a ram of GRID_ROWS words of GRID_COLS bits; one command transaction
// is taken at a time and gives one result transaction. A generation step reads the used
// rows one per cycle through the ram read port, keeps the two previous old rows in a
// window and writes each updated row back; with no rows used it goes straight to the
// result. Clear sweeps every stored row. Flip, write and read skip the ram when the
// address is out of range, as do unknown actions. After reset a clearing pass zeroes
// the ram before the first command is taken; configuration writes are taken throughout.
// The next command may be taken while a result waits.

module life_grid_generation_engine #(
	parameter int GRID_ROWS = lgge_pkg::LGGE_GRID_ROWS_DEF,
	parameter int GRID_COLS = lgge_pkg::LGGE_GRID_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lgge_pkg::APB_AW-1:0] paddr,
	input  logic [lgge_pkg::APB_DW-1:0] pwdata,
	output logic [lgge_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	lgge_in_if.sink                     in_ch,
	lgge_out_if.source                  out_ch
);

	import lgge_pkg::*;

	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CIW   = $clog2(GRID_COLS);
	localparam int RCMPW = ($clog2(GRID_ROWS + 1) > CFG_W) ? $clog2(GRID_ROWS + 1) : CFG_W;
	localparam int CCMPW = ($clog2(GRID_COLS + 1) > CFG_W) ? $clog2(GRID_COLS + 1) : CFG_W;
	localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);

	state_t                 state_q, state_d;
	logic [CFG_W-1:0]       rows_used_q, cols_used_q;
	logic [GEN_W-1:0]       gen_q;
	logic [RW-1:0]          rd_row_q;
	logic                   dv_s1;
	logic [RW-1:0]          drow_s1;
	logic [GRID_COLS-1:0]   above_q, here_q;
	logic [RW-1:0]          here_row_q;
	logic                   chg_q;
	action_t                act_q;
	logic [RW-1:0]          row_q;
	logic [CIW-1:0]         col_q;
	logic                   val_q;
	logic                   res_cell_q, res_chg_q, res_oor_q;
	logic                   out_valid_q;
	logic                   out_cell_q, out_chg_q, out_oor_q;
	logic [GEN_W-1:0]       out_gen_q;

	logic [RCMPW-1:0]       nr, nr_last, in_row_ext;
	logic [CCMPW-1:0]       nc, in_col_ext;
	logic [GRID_COLS-1:0]   col_mask;
	action_t                in_act;
	logic                   in_acc, cell_act, in_rng, nr_zero;
	logic                   ram_we, ram_re;
	logic [RW-1:0]          ram_waddr, ram_raddr;
	logic [GRID_COLS-1:0]   ram_wdata, ram_rdata;
	logic [GRID_COLS-1:0]   rule_above, rule_below, rule_nxt;
	logic                   rule_chg;
	logic                   old_bit, new_bit, step_wr, out_load;
	logic [GRID_COLS-1:0]   cell_wd;

	// used area, clamped to storage
	always_comb begin
		nr = (RCMPW'(rows_used_q) > RCMPW'(GRID_ROWS)) ? RCMPW'(GRID_ROWS) : RCMPW'(rows_used_q);
		nc = (CCMPW'(cols_used_q) > CCMPW'(GRID_COLS)) ? CCMPW'(GRID_COLS) : CCMPW'(cols_used_q);
		for (int c = 0; c < GRID_COLS; c++) begin
			col_mask[c] = CCMPW'(c) < nc;
		end
	end

	assign nr_last    = nr - RCMPW'(1);
	assign nr_zero    = (nr == '0);
	assign in_act     = action_t'(in_ch.action);
	assign in_acc     = in_ch.valid && in_ch.ready;
	assign cell_act   = in_act inside {ACT_FLIP, ACT_WRITE, ACT_READ};
	assign in_row_ext = RCMPW'(in_ch.row);
	assign in_col_ext = CCMPW'(in_ch.col);
	assign in_rng     = (in_row_ext < nr) && (in_col_ext < nc);

	// configuration port
	assign pready = 1'b1;

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_ROWS_USED: prdata = APB_DW'(rows_used_q);
			REG_COLS_USED: prdata = APB_DW'(cols_used_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= ROWS_USED_RST;
			cols_used_q <= COLS_USED_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[2]))
				REG_ROWS_USED: rows_used_q <= pwdata[CFG_W-1:0];
				REG_COLS_USED: cols_used_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// grid storage and row update
	lgge_ram #(
		.WIDTH(GRID_COLS),
		.DEPTH(GRID_ROWS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rule_above = (here_row_q == '0) ? '0 : above_q;
	assign rule_below = (state_q == S_STEP_LAST) ? '0 : ram_rdata;

	lgge_row_rule #(
		.COLS(GRID_COLS)
	) u_rule (
		.above(rule_above),
		.here (here_q),
		.below(rule_below),
		.mask (col_mask),
		.nxt  (rule_nxt),
		.chg  (rule_chg)
	);

	// single cell modify
	always_comb begin
		old_bit = ram_rdata[col_q];
		case (act_q)
			ACT_FLIP:  new_bit = ~old_bit;
			ACT_WRITE: new_bit = val_q;
			default:   new_bit = old_bit;
		endcase
		cell_wd        = ram_rdata;
		cell_wd[col_q] = new_bit;
	end

	assign step_wr = (((state_q == S_STEP) || (state_q == S_STEP_DRAIN)) && dv_s1
		&& (drow_s1 != '0)) || (state_q == S_STEP_LAST);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = rd_row_q;
		ram_we    = 1'b0;
		ram_waddr = rd_row_q;
		ram_wdata = '0;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				if (rd_row_q == ROW_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_ch.valid) begin
					if (in_act == ACT_STEP) begin
						state_d = nr_zero ? S_DONE : S_STEP;
					end else if (in_act == ACT_CLEAR) begin
						state_d = S_CLR;
					end else if (cell_act && in_rng) begin
						ram_re    = 1'b1;
						ram_raddr = in_row_ext[RW-1:0];
						state_d   = S_CELL;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_CELL: begin
				ram_we    = (act_q == ACT_FLIP) || (act_q == ACT_WRITE);
				ram_waddr = row_q;
				ram_wdata = cell_wd;
				state_d   = S_DONE;
			end
			S_CLR: begin
				ram_re = 1'b1;
				ram_we = 1'b1;
				if (rd_row_q == ROW_LAST) begin
					state_d = S_CLR_TAIL;
				end
			end
			S_CLR_TAIL: begin
				state_d = S_DONE;
			end
			S_STEP: begin
				ram_re    = 1'b1;
				ram_we    = step_wr;
				ram_waddr = here_row_q;
				ram_wdata = rule_nxt;
				if (RCMPW'(rd_row_q) == nr_last) begin
					state_d = S_STEP_DRAIN;
				end
			end
			S_STEP_DRAIN: begin
				ram_we    = step_wr;
				ram_waddr = here_row_q;
				ram_wdata = rule_nxt;
				state_d   = S_STEP_LAST;
			end
			S_STEP_LAST: begin
				ram_we    = 1'b1;
				ram_waddr = here_row_q;
				ram_wdata = rule_nxt;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == S_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_row_q    <= '0;
			dv_s1       <= 1'b0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			dv_s1 <= (state_q == S_STEP) || (state_q == S_CLR);
			if (in_acc) begin
				rd_row_q <= '0;
			end else if ((state_q == S_INIT) || (state_q == S_CLR) || (state_q == S_STEP)) begin
				rd_row_q <= rd_row_q + RW'(1);
			end
			if ((in_acc && (in_act == ACT_STEP) && nr_zero) || (state_q == S_STEP_LAST)) begin
				gen_q <= gen_q + GEN_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		drow_s1 <= rd_row_q;
		if (((state_q == S_STEP) || (state_q == S_STEP_DRAIN)) && dv_s1) begin
			above_q    <= here_q;
			here_q     <= ram_rdata;
			here_row_q <= drow_s1;
		end
		if (in_acc) begin
			act_q      <= in_act;
			row_q      <= in_row_ext[RW-1:0];
			col_q      <= in_col_ext[CIW-1:0];
			val_q      <= in_ch.value;
			chg_q      <= 1'b0;
			res_cell_q <= 1'b0;
			res_chg_q  <= 1'b0;
			res_oor_q  <= cell_act && !in_rng;
		end else if ((state_q == S_CLR) && dv_s1) begin
			chg_q <= chg_q | (|ram_rdata);
		end else if (step_wr && (state_q != S_STEP_LAST)) begin
			chg_q <= chg_q | rule_chg;
		end
		case (state_q)
			S_CELL: begin
				res_cell_q <= new_bit;
				res_chg_q  <= (act_q == ACT_FLIP) || ((act_q == ACT_WRITE) && (old_bit != val_q));
			end
			S_CLR_TAIL: res_chg_q <= chg_q | (dv_s1 && (|ram_rdata));
			S_STEP_LAST: res_chg_q <= chg_q | rule_chg;
			default: ;
		endcase
		if (out_load) begin
			out_cell_q <= res_cell_q;
			out_chg_q  <= res_chg_q;
			out_oor_q  <= res_oor_q;
			out_gen_q  <= gen_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.cell_state   = out_cell_q;
	assign out_ch.changed      = out_chg_q;
	assign out_ch.out_of_range = out_oor_q;
	assign out_ch.generation   = out_gen_q;

endmodule

// ----- rtl/lgge_checker.sv -----
// lgge_props: port-level assertions for life_grid_generation_engine, bound to the top
// depends on lgge_pkg for field widths

module lgge_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pready,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        cell_state,
	input logic                        changed,
	input logic                        out_of_range,
	input logic [lgge_pkg::GEN_W-1:0]  generation
);

	import lgge_pkg::*;

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(generation) && $stable(cell_state)
			&& $stable(changed) && $stable(out_of_range))
		else $error("result changed while stalled");

	// one command transaction at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while busy");

	// an out of range result reports no cell state and no change
	a_oor_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> !cell_state && !changed)
		else $error("out of range result reports a cell");

	// config port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind life_grid_generation_engine lgge_props u_lgge_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.pready      (pready),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.cell_state  (out_ch.cell_state),
	.changed     (out_ch.changed),
	.out_of_range(out_ch.out_of_range),
	.generation  (out_ch.generation)
);

// ----- sim/lgge_checker.sv -----
// lgge_checker: predicts every result transaction of the life grid engine and compares it
// watches the command, result and apb channels; depends on lgge_pkg and lgge_if

module lgge_checker import lgge_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	lgge_in_if                cmd_ch,
	lgge_out_if               res_ch,
	output int                mismatches,
	output int                outstanding
);

	localparam int NR = LGGE_GRID_ROWS_DEF;
	localparam int NC = LGGE_GRID_COLS_DEF;

	typedef logic [NC-1:0] grid_row_t;

	typedef struct packed {
		logic             cell_state;
		logic [GEN_W-1:0] generation;
		logic             changed;
		logic             out_of_range;
	} life_result_t;

	grid_row_t        cells [NR];
	logic [GEN_W-1:0] gen_count;
	logic [CFG_W-1:0] rows_cfg;
	logic [CFG_W-1:0] cols_cfg;
	life_result_t     awaited [$];

	always @(posedge clk or negedge arst_n) begin : watch
		int           nr;
		int           nc;
		int           r;
		grid_row_t    colmask;
		grid_row_t    above;
		grid_row_t    here;
		grid_row_t    below;
		grid_row_t    s0;
		grid_row_t    s1;
		grid_row_t    s2;
		grid_row_t    carry;
		grid_row_t    nxt;
		grid_row_t    old_rows [NR];
		grid_row_t    nbrs [8];
		life_result_t want;
		life_result_t got;
		if (!arst_n) begin
			foreach (cells[i])
				cells[i] = '0;
			gen_count  = '0;
			rows_cfg   = ROWS_USED_RST;
			cols_cfg   = COLS_USED_RST;
			awaited.delete();
			mismatches = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.cell_state   = res_ch.cell_state;
				got.generation   = res_ch.generation;
				got.changed      = res_ch.changed;
				got.out_of_range = res_ch.out_of_range;
				if (awaited.size() == 0) begin
					$error("result transaction with nothing outstanding");
					mismatches++;
				end else begin
					want = awaited.pop_front();
					if (got.cell_state !== want.cell_state) begin
						$error("cell_state: expected %0d, got %0d", want.cell_state, got.cell_state);
						mismatches++;
					end
					if (got.generation !== want.generation) begin
						$error("generation: expected %0d, got %0d", want.generation, got.generation);
						mismatches++;
					end
					if (got.changed !== want.changed) begin
						$error("changed: expected %0d, got %0d", want.changed, got.changed);
						mismatches++;
					end
					if (got.out_of_range !== want.out_of_range) begin
						$error("out_of_range: expected %0d, got %0d", want.out_of_range,
							got.out_of_range);
						mismatches++;
					end
				end
			end

			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[APB_AW-1:2]))
						REG_ROWS_USED: rows_cfg = pwdata[CFG_W-1:0];
						REG_COLS_USED: cols_cfg = pwdata[CFG_W-1:0];
						default: ;
					endcase
				end else begin
					want.generation = (reg_idx_t'(paddr[APB_AW-1:2]) == REG_ROWS_USED) ?
						GEN_W'(rows_cfg) : GEN_W'(cols_cfg);
					if (prdata !== APB_DW'(want.generation)) begin
						$error("prdata: expected %0d, got %0d", want.generation, prdata);
						mismatches++;
					end
				end
			end

			if (cmd_ch.valid && cmd_ch.ready) begin
				nr      = (rows_cfg > NR) ? NR : rows_cfg;
				nc      = (cols_cfg > NC) ? NC : cols_cfg;
				colmask = (nc >= NC) ? '1 : ((grid_row_t'(1) << nc) - 1'b1);
				want    = '0;
				case (cmd_ch.action)
					ACT_STEP: begin
						old_rows = cells;
						for (r = 0; r < nr; r++) begin
							here  = old_rows[r] & colmask;
							above = (r > 0) ? (old_rows[r-1] & colmask) : '0;
							below = (r + 1 < nr) ? (old_rows[r+1] & colmask) : '0;
							nbrs  = '{above << 1, above, above >> 1, here << 1, here >> 1,
								below << 1, below, below >> 1};
							s0 = '0;
							s1 = '0;
							s2 = '0;
							// bit-sliced neighbor count, s2 sticks once the count reaches four
							foreach (nbrs[k]) begin
								carry = s0 & nbrs[k];
								s0    = s0 ^ nbrs[k];
								s2    = s2 | (s1 & carry);
								s1    = s1 ^ carry;
							end
							nxt = s1 & ~s2 & (s0 | here);
							if (|((nxt ^ here) & colmask))
								want.changed = 1'b1;
							cells[r] = (nxt & colmask) | (old_rows[r] & ~colmask);
						end
						gen_count++;
					end
					ACT_CLEAR: begin
						foreach (cells[i]) begin
							if (|cells[i])
								want.changed = 1'b1;
							cells[i] = '0;
						end
					end
					ACT_FLIP, ACT_WRITE, ACT_READ: begin
						if (cmd_ch.row >= nr || cmd_ch.col >= nc) begin
							want.out_of_range = 1'b1;
						end else begin
							if (cmd_ch.action == ACT_FLIP) begin
								cells[cmd_ch.row][cmd_ch.col] = ~cells[cmd_ch.row][cmd_ch.col];
								want.changed = 1'b1;
							end else if (cmd_ch.action == ACT_WRITE) begin
								want.changed = cells[cmd_ch.row][cmd_ch.col] != cmd_ch.value;
								cells[cmd_ch.row][cmd_ch.col] = cmd_ch.value;
							end
							want.cell_state = cells[cmd_ch.row][cmd_ch.col];
						end
					end
					default: ;
				endcase
				want.generation = gen_count;
				awaited.push_back(want);
			end
		end
		outstanding = awaited.size();
	end

endmodule

// ----- sim/tb_top.sv -----
// tb_top: stimulus, handshake pacing and verdict for the life grid generation engine
// depends on lgge_pkg, lgge_if, the engine rtl and lgge_checker

module tb_top;
	import lgge_pkg::*;

	localparam int NR             = LGGE_GRID_ROWS_DEF;
	localparam int NC             = LGGE_GRID_COLS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int END_DRAIN      = 150;
	localparam int PHASES         = 12;
	localparam int HOLD_PHASE     = 10;
	localparam int PHASE_ROWS  [PHASES] = '{128, 16, 0, 255, 1, 3, 2, 128, 8, 100, 40, 128};
	localparam int PHASE_COLS  [PHASES] = '{128, 16, 0, 255, 1, 7, 128, 1, 255, 100, 20, 128};
	localparam int PHASE_ITEMS [PHASES] = '{120, 150, 30, 80, 40, 80, 60, 50, 80, 100, 100, 100};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                mismatches;
	int                outstanding;
	int                idle_cycles = 0;
	logic              calm        = 1'b0;
	logic              hold_req    = 1'b0;
	logic              hold_done   = 1'b0;
	int                eff_rows;
	int                eff_cols;
	int                hot_r;
	int                hot_c;

	lgge_in_if  cmd_ch ();
	lgge_out_if res_ch ();

	life_grid_generation_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (cmd_ch),
		.out_ch  (res_ch)
	);

	lgge_checker grid_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cmd_ch      (cmd_ch),
		.res_ch      (res_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side pacing, including one long hold that backs the engine up
	initial begin
		int   n;
		logic lvl;
		forever begin
			if (hold_req && !hold_done) begin
				lvl       = 1'b0;
				n         = LONG_HOLD;
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				lvl = 1'b0;
				n   = $urandom_range(1, 4);
			end else begin
				lvl = 1'b1;
				n   = $urandom_range(1, 6);
			end
			res_ch.ready <= lvl;
			repeat (n) @(negedge clk);
		end
	end

	task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_grid_size(input int rows, input int cols);
		logic [APB_DW-1:0] data;
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		data            = $urandom();
		data[CFG_W-1:0] = CFG_W'(rows);
		apb_xfer(1'b1, REG_ROWS_USED, data);
		data            = $urandom();
		data[CFG_W-1:0] = CFG_W'(cols);
		apb_xfer(1'b1, REG_COLS_USED, data);
		apb_xfer(1'b0, REG_ROWS_USED, '0);
		apb_xfer(1'b0, REG_COLS_USED, '0);
		eff_rows = (rows > NR) ? NR : rows;
		eff_cols = (cols > NC) ? NC : cols;
		hot_r    = 0;
		hot_c    = 0;
	endtask

	task automatic send_cmd(input logic [ACTION_W-1:0] act, input int row, input int col,
		input logic val);
		if (!calm && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid  <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.row    <= row[ROW_W-1:0];
		cmd_ch.col    <= col[COL_W-1:0];
		cmd_ch.value  <= val;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	function automatic void pick_cell(input bit in_area, output int row, output int col);
		if (in_area && eff_rows > 0 && eff_cols > 0) begin
			if ($urandom_range(0, 3) != 0) begin
				row = hot_r + $urandom_range(0, 4);
				col = hot_c + $urandom_range(0, 4);
				if (row >= eff_rows)
					row = eff_rows - 1;
				if (col >= eff_cols)
					col = eff_cols - 1;
			end else begin
				row = $urandom_range(0, eff_rows - 1);
				col = $urandom_range(0, eff_cols - 1);
			end
		end else if (eff_rows < NR && (eff_cols >= NC || $urandom_range(0, 1) == 0)) begin
			row = $urandom_range(eff_rows, NR - 1);
			col = $urandom_range(0, NC - 1);
		end else if (eff_cols < NC) begin
			row = $urandom_range(0, NR - 1);
			col = $urandom_range(eff_cols, NC - 1);
		end else begin
			row = $urandom_range(0, NR - 1);
			col = $urandom_range(0, NC - 1);
		end
	endfunction

	task automatic send_random();
		int                  p;
		int                  row;
		int                  col;
		logic [ACTION_W-1:0] act;
		logic                val;
		// keep most edits in a small window so patterns actually evolve
		if ($urandom_range(0, 19) == 0 && eff_rows > 0 && eff_cols > 0) begin
			hot_r = $urandom_range(0, eff_rows - 1);
			hot_c = $urandom_range(0, eff_cols - 1);
		end
		p   = $urandom_range(0, 99);
		val = ($urandom_range(0, 9) < 7);
		pick_cell(p < 87, row, col);
		if (p < 40)
			act = ACT_WRITE;
		else if (p < 52)
			act = ACT_FLIP;
		else if (p < 72)
			act = ACT_STEP;
		else if (p < 84)
			act = ACT_READ;
		else if (p < 87)
			act = ACT_CLEAR;
		else if (p < 95) begin
			case ($urandom_range(0, 2))
				0:       act = ACT_FLIP;
				1:       act = ACT_WRITE;
				default: act = ACT_READ;
			endcase
		end else begin
			act = ACT_READ + ACTION_W'($urandom_range(1, 3));
			row = $urandom_range(0, NR - 1);
			col = $urandom_range(0, NC - 1);
		end
		send_cmd(act, row, col, val);
	endtask

	initial begin
		int ph;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.action = ACT_STEP;
		cmd_ch.row    = '0;
		cmd_ch.col    = '0;
		cmd_ch.value  = 1'b0;
		eff_rows      = ROWS_USED_RST;
		eff_cols      = COLS_USED_RST;
		hot_r         = 0;
		hot_c         = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: corners, out of range, dying cell, blinker, unknown codes, clears
		send_cmd(ACT_READ, 0, 0, 1'b0);
		send_cmd(ACT_WRITE, 0, 0, 1'b1);
		send_cmd(ACT_WRITE, 0, 0, 1'b1);
		send_cmd(ACT_FLIP, 0, 0, 1'b0);
		send_cmd(ACT_WRITE, eff_rows - 1, eff_cols - 1, 1'b1);
		send_cmd(ACT_READ, eff_rows - 1, eff_cols - 1, 1'b0);
		send_cmd(ACT_READ, eff_rows, 0, 1'b0);
		send_cmd(ACT_WRITE, 0, eff_cols, 1'b1);
		send_cmd(ACT_FLIP, NR - 1, NC - 1, 1'b1);
		send_cmd(ACT_STEP, 0, 0, 1'b0);
		send_cmd(ACT_STEP, 0, 0, 1'b0);
		send_cmd(ACT_WRITE, 50, 10, 1'b1);
		send_cmd(ACT_WRITE, 50, 11, 1'b1);
		send_cmd(ACT_WRITE, 50, 12, 1'b1);
		send_cmd(ACT_STEP, 0, 0, 1'b0);
		send_cmd(ACT_READ, 49, 11, 1'b0);
		send_cmd(ACT_STEP, NR - 1, NC - 1, 1'b1);
		send_cmd(ACT_READ, 49, 11, 1'b0);
		send_cmd(ACT_READ + ACTION_W'(1), NR - 1, NC - 1, 1'b1);
		send_cmd(ACT_READ + ACTION_W'(3), NR - 1, NC - 1, 1'b1);
		send_cmd(ACT_CLEAR, 0, 0, 1'b0);
		send_cmd(ACT_CLEAR, NR - 1, NC - 1, 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			set_grid_size(PHASE_ROWS[ph], PHASE_COLS[ph]);
			if (ph == HOLD_PHASE)
				hold_req = 1'b1;
			if (ph == PHASES - 1)
				calm = 1'b1;
			repeat (PHASE_ITEMS[ph]) send_random();
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (END_DRAIN) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
